// ===== hw/rtl/sams_pkg.sv =====
// Types and constants shared by the shared-array multi-stack, its checker and the testbench.
package sams_pkg;

  localparam int unsigned DEF_NUM_STACKS  = 4;
  localparam int unsigned DEF_NUM_SLOTS   = 16;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  localparam int unsigned STACK_ID_W = 2;
  localparam int unsigned PORT_VAL_W = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e_t;

  typedef struct packed {
    op_e_t                         kind;
    logic [STACK_ID_W-1:0]         stack_id;
    logic signed [PORT_VAL_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    status_e_t                     status;
    logic signed [PORT_VAL_W-1:0]  pop_value;
  } rsp_t;

endpackage

// ===== hw/rtl/shared_array_multi_stack.sv =====
// Top level of the shared-array multi-stack: several stacks chained through one slot store.
// A request is taken on any clock edge where start is high and busy is low, so one request
// may enter every cycle; busy is high only while reset is applied. Each request passes an
// input register and then a result register, after which its result appears on rsp with done
// high for exactly one cycle; the receiver cannot hold it off. Results come out in request
// order. The head pointers, the free-list pointer and the link table sit in flip-flops that
// are read and written back in the same cycle, so a request that depends on the one before it
// can follow in the very next cycle. Reset restores the free list at once; there is no
// clearing pass.
module shared_array_multi_stack
  import sams_pkg::*;
#(
  parameter int unsigned NUM_STACKS  = DEF_NUM_STACKS,
  parameter int unsigned NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int unsigned PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned EXT_W  = VALUE_WIDTH + PORT_VAL_W;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

  logic [PTR_W-1:0]       slot_link [NUM_SLOTS];
  logic [VALUE_WIDTH-1:0] slot_data [NUM_SLOTS];
  logic [PTR_W-1:0]       stack_head [NUM_STACKS];
  logic [PTR_W-1:0]       free_head;

  req_t req_q;
  logic req_valid;

  logic [SID_W+STACK_ID_W-1:0] sid_ext;
  logic [SID_W-1:0]            sid_idx;
  logic                        sid_ok;
  logic [PTR_W-1:0]            head_rd;
  logic                        head_live;
  logic                        free_live;
  logic [PTR_W-1:0]            rd_ptr;
  logic [SLOT_W-1:0]           rd_idx;
  logic [PTR_W-1:0]            link_rd;
  logic [VALUE_WIDTH-1:0]      data_rd;
  logic signed [EXT_W-1:0]     push_ext;
  logic signed [EXT_W-1:0]     pop_ext;
  logic                        do_push;
  logic                        do_pop;
  rsp_t                        rsp_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    if (start && !busy) begin
      req_q <= req;
    end
  end

  always_comb begin
    sid_ext   = {{SID_W{1'b0}}, req_q.stack_id};
    sid_idx   = sid_ext[SID_W-1:0];
    sid_ok    = (sid_ext < (SID_W + STACK_ID_W)'(NUM_STACKS));
    head_rd   = sid_ok ? stack_head[sid_idx] : NULL_PTR;
    head_live = sid_ok && (head_rd < NULL_PTR);
    free_live = (free_head < NULL_PTR);
    rd_ptr    = (req_q.kind == OP_POP) ? head_rd : free_head;
    rd_idx    = rd_ptr[SLOT_W-1:0];
    link_rd   = slot_link[rd_idx];
    data_rd   = slot_data[rd_idx];
    push_ext  = EXT_W'(req_q.push_value);
    pop_ext   = EXT_W'(signed'(data_rd));
    do_push   = req_valid && (req_q.kind == OP_PUSH) && sid_ok && free_live;
    do_pop    = req_valid && (req_q.kind == OP_POP) && head_live;

    rsp_next.status    = ST_OK;
    rsp_next.pop_value = '0;
    if (req_q.kind == OP_PUSH) begin
      if (!(sid_ok && free_live)) begin
        rsp_next.status = ST_OVERFLOW;
      end
    end else begin
      if (head_live) begin
        rsp_next.pop_value = pop_ext[PORT_VAL_W-1:0];
      end else begin
        rsp_next.status    = ST_UNDERFLOW;
        rsp_next.pop_value = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_link[i] <= PTR_W'(i + 1);
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
        stack_head[s] <= NULL_PTR;
      end
      free_head <= '0;
    end else if (do_push) begin
      free_head           <= link_rd;
      slot_link[rd_idx]   <= head_rd;
      stack_head[sid_idx] <= rd_ptr;
    end else if (do_pop) begin
      stack_head[sid_idx] <= link_rd;
      slot_link[rd_idx]   <= free_head;
      free_head           <= rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_data[rd_idx] <= push_ext[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
    if (req_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== hw/rtl/sams_checker.sv =====
// Port-level checker for the shared-array multi-stack, bound to the top level.
module sams_checker
  import sams_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t rsp
);

  a_busy_only_in_reset: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy is high outside reset");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("a request produced no result two cycles later");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("a result appeared without a matching request");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.kind == OP_PUSH, 2)) |->
      (rsp.pop_value == '0 && rsp.status != ST_UNDERFLOW))
    else $error("a push gave a non-zero value or an underflow");

  a_underflow_value: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_UNDERFLOW) |-> rsp.pop_value == '1)
    else $error("an underflow did not return minus one");

endmodule

bind shared_array_multi_stack sams_checker u_sams_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the shared-array multi-stack: directed and random push and pop traffic.
module tb;
  import sams_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSTK  = DEF_NUM_STACKS;
  localparam int unsigned NSLOT = DEF_NUM_SLOTS;
  localparam int unsigned PTR_W = $clog2(NSLOT + 1);
  localparam int unsigned SLOT_W = $clog2(NSLOT);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NSLOT);
  localparam int unsigned N_RANDOM = 1630;
  localparam int unsigned CALM_TAIL = 200;

  typedef struct {
    req_t        rq;
    int unsigned gap;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  pending_t pend_q[$];
  rsp_t     outcome_q[$];

  logic signed [PORT_VAL_W-1:0] slot_val[NSLOT];
  logic [PTR_W-1:0]             slot_next[NSLOT];
  logic [PTR_W-1:0]             top_of[NSTK];
  logic [PTR_W-1:0]             free_top;

  int unsigned err_count = 0;
  int unsigned n_push = 0;
  int unsigned n_pop = 0;
  int unsigned n_over = 0;
  int unsigned n_under = 0;
  int unsigned n_checked = 0;

  shared_array_multi_stack u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic clear_stacks();
    for (int i = 0; i < NSLOT; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = PTR_W'(i + 1);
    end
    for (int s = 0; s < NSTK; s++) begin
      top_of[s] = NIL;
    end
    free_top = '0;
  endtask

  function automatic rsp_t apply_stack_op(req_t r);
    rsp_t              o;
    logic [PTR_W-1:0]  idx;
    logic [SLOT_W-1:0] si;
    o.status    = ST_OK;
    o.pop_value = '0;
    if (r.kind == OP_PUSH) begin
      n_push++;
      if (int'(r.stack_id) >= NSTK || free_top >= NIL) begin
        o.status = ST_OVERFLOW;
        n_over++;
      end else begin
        idx                = free_top;
        si                 = idx[SLOT_W-1:0];
        free_top           = slot_next[si];
        slot_next[si]      = top_of[r.stack_id];
        top_of[r.stack_id] = idx;
        slot_val[si]       = r.push_value;
      end
    end else begin
      n_pop++;
      if (int'(r.stack_id) >= NSTK || top_of[r.stack_id] >= NIL) begin
        o.status    = ST_UNDERFLOW;
        o.pop_value = -32'sd1;
        n_under++;
      end else begin
        idx                = top_of[r.stack_id];
        si                 = idx[SLOT_W-1:0];
        top_of[r.stack_id] = slot_next[si];
        slot_next[si]      = free_top;
        free_top           = idx;
        o.pop_value        = slot_val[si];
      end
    end
    return o;
  endfunction

  task automatic add_request(op_e_t k, int unsigned sid, logic [31:0] v, int unsigned gap);
    pending_t p;
    p.rq.kind       = k;
    p.rq.stack_id   = STACK_ID_W'(sid);
    p.rq.push_value = v;
    p.gap           = gap;
    pend_q = {pend_q, p};
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Driver: holds each request until the handshake takes it, then predicts its result.
  always @(posedge clk) begin
    logic nxt_start;
    req_t nxt_req;
    if (!rst) begin
      nxt_start = start;
      nxt_req   = req;
      if (start && !busy) begin
        outcome_q = {outcome_q, apply_stack_op(req)};
        nxt_start = 1'b0;
      end
      if (!nxt_start && pend_q.size() > 0) begin
        if (pend_q[0].gap > 0) begin
          pend_q[0].gap--;
        end else begin
          nxt_req   = pend_q[0].rq;
          nxt_start = 1'b1;
          pend_q.pop_front();
        end
      end
      start <= nxt_start;
      req   <= nxt_req;
    end
  end

  // Monitor: every done pulse is matched against the oldest predicted result.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(rsp), '0);
      end else begin
        want = outcome_q.pop_front();
        n_checked++;
        if (rsp.status !== want.status) begin
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        end
        if (rsp.pop_value !== want.pop_value) begin
          report_mismatch("pop_value", rsp.pop_value, want.pop_value);
        end
      end
    end
  end

  initial begin
    int unsigned made;
    int unsigned phase_len;
    int unsigned push_pct;
    int unsigned gap;
    bit          calm;
    int unsigned favoured;

    clear_stacks();

    // Pops of every empty stack, extreme values, then unwinding in LIFO order.
    for (int s = 0; s < NSTK; s++) begin
      add_request(OP_POP, s, $urandom, 0);
    end
    add_request(OP_PUSH, 0, 32'h7fff_ffff, 0);
    add_request(OP_PUSH, 1, 32'h8000_0000, 1);
    add_request(OP_PUSH, 2, 32'h0000_0000, 0);
    add_request(OP_PUSH, 3, 32'hffff_ffff, 2);
    add_request(OP_PUSH, 0, 32'h5555_aaaa, 0);
    add_request(OP_PUSH, 1, 32'haaaa_5555, 0);
    add_request(OP_POP, 0, 32'hffff_ffff, 0);
    add_request(OP_POP, 0, 32'h0000_0000, 0);
    add_request(OP_POP, 1, $urandom, 3);
    add_request(OP_POP, 1, $urandom, 0);
    add_request(OP_POP, 2, $urandom, 0);
    add_request(OP_POP, 3, $urandom, 0);
    add_request(OP_POP, 2, $urandom, 0);

    // Random phases each lean toward filling, balancing or draining the store, picked at random.
    made = 0;
    while (made < N_RANDOM) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      calm     = ($urandom_range(0, 2) == 0);
      favoured = $urandom_range(0, NSTK);
      for (int i = 0; i < phase_len && made < N_RANDOM; i++) begin
        gap = 0;
        if (!calm && made < N_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 6);
        end
        add_request(op_e_t'(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP),
                    (favoured < NSTK && $urandom_range(0, 1)) ? favoured
                                                              : $urandom_range(0, NSTK - 1),
                    pick_value(), gap);
        made++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pend_q.size() > 0 || start || outcome_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    $display("Checked %0d results: %0d pushes, %0d pops.", n_checked, n_push, n_pop);
    $display("Overflows seen: %0d, underflows seen: %0d.", n_over, n_under);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Timed out with %0d results outstanding.", outcome_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
